// ----- rtl/dfq_pkg.sv -----
`timescale 1ns / 1ps

package dfq_pkg;

  // Default sizes of the frame store.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_HANDLE_BITS = 16;

  // Fixed field widths.
  localparam int COUNT_W = 5;
  localparam int CNT_W   = 16;
  localparam int RATE_W  = 24;
  localparam int TIME_W  = 32;

  // Frames times 1000 ms times 256 needs 34 bits.
  localparam int DVD_W = 34;

  localparam logic [COUNT_W-1:0] DEFAULT_LIMIT = 5'd4;
  localparam logic [TIME_W-1:0]  WINDOW_MS     = 32'd1000;
  localparam logic [17:0]        RATE_SCALE    = 18'd256000;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;
  localparam logic [RATE_W-1:0]  RATE_MAX      = 24'hFFFFFF;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_READ,
    ST_DIV_WAIT,
    ST_RESP
  } state_t;

  // Command to the serial divider.
  typedef struct packed {
    logic              go;
    logic [DVD_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_cmd_t;

  // Response from the serial divider.
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Saturating increment of an event counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

// ----- rtl/dfq_ram.sv -----
`timescale 1ns / 1ps

module dfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dfq_div.sv -----
`timescale 1ns / 1ps

module dfq_div (
  input  logic              clk,
  input  logic              rst,
  input  dfq_pkg::div_cmd_t cmd,
  output dfq_pkg::div_rsp_t rsp
);
  import dfq_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              running;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [DVD_W-1:0]  dvd;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W-1:0] rem;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;
  logic [TIME_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        running <= 1'b1;
        steps   <= STEP_W'(DVD_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      dvd <= cmd.dividend;
      dvs <= cmd.divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// ----- rtl/drop_oldest_frame_queue_with_rate_meter_core.sv -----
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------
// request   | req_type, frame_handle, now_ms                    | start high, busy low
// result    | frame_valid, frame_out, queued_count, has_frames, | done, one cycle
//           | dropped_total, repeats_total, rate_q8             |
// config    | cfg_data (queue_limit)                            | cfg_write
//
// Done is shown in ST_RESP. An accepted word runs through ST_EXEC; a pop that reads the
// frame store also passes ST_POP_READ, and a push that closes a rate window waits in
// ST_DIV_WAIT while the serial divider produces one quotient bit per cycle over 34
// dividend bits. A new word is accepted only from ST_IDLE, in the cycle after done.
// Reset is synchronous and active high; it clears the queue and counters and sets
// the limit back to four.
// Busy stays high until the result has been shown; the receiver cannot stall.
`timescale 1ns / 1ps

module drop_oldest_frame_queue_with_rate_meter_core #(
  parameter int QUEUE_DEPTH = dfq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = dfq_pkg::DEF_HANDLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [HANDLE_BITS-1:0]      frame_handle,
  input  logic [dfq_pkg::TIME_W-1:0]  now_ms,
  output logic                        done,
  output logic                        frame_valid,
  output logic [HANDLE_BITS-1:0]      frame_out,
  output logic [dfq_pkg::COUNT_W-1:0] queued_count,
  output logic                        has_frames,
  output logic [dfq_pkg::CNT_W-1:0]   dropped_total,
  output logic [dfq_pkg::CNT_W-1:0]   repeats_total,
  output logic [dfq_pkg::RATE_W-1:0]  rate_q8,
  input  logic                        cfg_write,
  input  logic [dfq_pkg::COUNT_W-1:0] cfg_data
);
  import dfq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  state_t state, state_next;

  // Latched request word.
  req_t                   req;
  logic [HANDLE_BITS-1:0] handle;
  logic [TIME_W-1:0]      now;

  // Queue and meter state.
  logic [COUNT_W-1:0]     queue_limit;
  logic [IDX_W-1:0]       head;
  logic [COUNT_W-1:0]     count;
  logic [HANDLE_BITS-1:0] held_handle;
  logic                   held_valid;
  logic [CNT_W-1:0]       drop_counter;
  logic [CNT_W-1:0]       repeat_counter;
  logic [RATE_W-1:0]      rate_value;
  logic [CNT_W-1:0]       window_frames;
  logic [TIME_W-1:0]      window_start;
  logic                   window_started;

  // Push and pop arithmetic.
  logic [COUNT_W-1:0]     limit_eff;
  logic                   at_limit;
  logic                   drop_front;
  logic                   store;
  logic [IDX_W-1:0]       head_inc;
  logic [IDX_W-1:0]       head_adv;
  logic [COUNT_W-1:0]     cnt_mid;
  logic [SUM_W-1:0]       slot_sum;
  logic [IDX_W-1:0]       waddr;
  logic [TIME_W-1:0]      ws_eff;
  logic [CNT_W-1:0]       wf_inc;
  logic [TIME_W-1:0]      elapsed;
  logic                   window_close;

  // Sequencer outputs.
  logic                   ram_we;
  logic                   ram_re;
  logic [HANDLE_BITS-1:0] ram_rdata;
  div_cmd_t               div_cmd;
  div_rsp_t               div_rsp;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= DEFAULT_LIMIT;
    end else if (cfg_write) begin
      queue_limit <= cfg_data;
    end
  end

  // Effective limit, drop decision and the ring slot of a push.
  always_comb begin
    limit_eff = queue_limit;
    if (QUEUE_DEPTH < 32 && int'(queue_limit) > QUEUE_DEPTH) begin
      limit_eff = COUNT_W'(QUEUE_DEPTH);
    end
    at_limit   = (count >= limit_eff);
    drop_front = at_limit && (count != '0);
    store      = !(at_limit && (count == '0));
    head_inc   = (head == LAST_IDX) ? '0 : head + 1'b1;
    head_adv   = drop_front ? head_inc : head;
    cnt_mid    = count - COUNT_W'(drop_front);
    slot_sum   = SUM_W'(head_adv) + SUM_W'(cnt_mid);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    waddr = slot_sum[IDX_W-1:0];
  end

  // Rate window: a push opens it when closed, and closes it after a second.
  always_comb begin
    ws_eff       = window_started ? window_start : now;
    wf_inc       = sat_inc(window_started ? window_frames : '0);
    elapsed      = now - ws_eff;
    window_close = (elapsed >= WINDOW_MS);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        if (req == REQ_PUSH && window_close) begin
          state_next = ST_DIV_WAIT;
        end else if (req == REQ_POP && count != '0) begin
          state_next = ST_POP_READ;
        end
      end
      ST_POP_READ: state_next = ST_RESP;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy             = 1'b1;
    done             = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    div_cmd.go       = 1'b0;
    div_cmd.dividend = DVD_W'(wf_inc) * DVD_W'(RATE_SCALE);
    div_cmd.divisor  = elapsed;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        ram_we     = (req == REQ_PUSH) && store;
        ram_re     = (req == REQ_POP) && (count != '0);
        div_cmd.go = (req == REQ_PUSH) && window_close;
      end
      ST_POP_READ: busy = 1'b1;
      ST_DIV_WAIT: busy = 1'b1;
      ST_RESP:     done = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request word at acceptance.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req    <= req_t'(req_type);
      handle <= frame_handle;
      now    <= now_ms;
    end
  end

  // Queue, counters and rate window.
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      count          <= '0;
      held_handle    <= '0;
      held_valid     <= 1'b0;
      drop_counter   <= '0;
      repeat_counter <= '0;
      rate_value     <= '0;
      window_frames  <= '0;
      window_start   <= '0;
      window_started <= 1'b0;
    end else begin
      if (state == ST_EXEC) begin
        case (req)
          REQ_PUSH: begin
            if (at_limit) begin
              drop_counter <= sat_inc(drop_counter);
            end
            head           <= head_adv;
            count          <= cnt_mid + COUNT_W'(store);
            window_started <= 1'b1;
            if (window_close) begin
              window_frames <= '0;
              window_start  <= now;
            end else begin
              window_frames <= wf_inc;
              window_start  <= ws_eff;
            end
          end
          REQ_POP: begin
            if (count != '0) begin
              head  <= head_inc;
              count <= count - 1'b1;
            end else begin
              repeat_counter <= sat_inc(repeat_counter);
            end
          end
          REQ_FLUSH: begin
            held_handle    <= '0;
            held_valid     <= 1'b0;
            head           <= '0;
            count          <= '0;
            drop_counter   <= '0;
            repeat_counter <= '0;
            rate_value     <= '0;
            window_frames  <= '0;
            window_started <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_POP_READ) begin
        held_handle <= ram_rdata;
        held_valid  <= 1'b1;
      end
      if (state == ST_DIV_WAIT && div_rsp.done) begin
        if (|div_rsp.quotient[DVD_W-1:RATE_W]) begin
          rate_value <= RATE_MAX;
        end else begin
          rate_value <= div_rsp.quotient[RATE_W-1:0];
        end
      end
    end
  end

  dfq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (handle),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  dfq_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  // Result fields.
  assign frame_valid   = (req == REQ_POP) && held_valid;
  assign frame_out     = frame_valid ? held_handle : '0;
  assign queued_count  = count;
  assign has_frames    = (count != '0) || held_valid;
  assign dropped_total = drop_counter;
  assign repeats_total = repeat_counter;
  assign rate_q8       = rate_value;

  // An accepted word always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // One result per word: done never repeats back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The queue never holds more entries than the store has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("entry count exceeds store depth");

  // The divider only answers while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  // A pop that reads the store always leaves a held frame behind.
  a_pop_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP_READ |=> held_valid)
    else $error("pop read did not set the held frame");

endmodule

// ----- bench/drop_oldest_frame_queue_with_rate_meter_core_tb.sv -----
`timescale 1ns / 1ps

module drop_oldest_frame_queue_with_rate_meter_core_tb;
  import dfq_pkg::*;

  localparam int DEPTH        = DEF_QUEUE_DEPTH;
  localparam int HB           = DEF_HANDLE_BITS;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_WORDS  = 190;

  // One result word as the block presents it.
  typedef struct packed {
    logic               frame_valid;
    logic [HB-1:0]      frame_out;
    logic [COUNT_W-1:0] queued_count;
    logic               has_frames;
    logic [CNT_W-1:0]   dropped_total;
    logic [CNT_W-1:0]   repeats_total;
    logic [RATE_W-1:0]  rate_q8;
  } frame_status_t;

  // Mirror of the frame queue and rate meter, plus the list of status words
  // still owed by the block.
  class frame_queue_scoreboard;
    logic [HB-1:0]      ring [DEPTH];
    int unsigned        head;
    int unsigned        count;
    logic [HB-1:0]      held;
    bit                 held_v;
    logic [CNT_W-1:0]   drops;
    logic [CNT_W-1:0]   repeats;
    logic [RATE_W-1:0]  rate;
    logic [CNT_W-1:0]   win_frames;
    logic [TIME_W-1:0]  win_start;
    bit                 win_open;
    logic [COUNT_W-1:0] limit;
    frame_status_t      status_q[$];
    int                 errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      win_start = '0;
      limit = DEFAULT_LIMIT;
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      held = '0;
      held_v = 0;
      head = 0;
      count = 0;
      drops = '0;
      repeats = '0;
      rate = '0;
      win_frames = '0;
      win_open = 0;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // Append with drop-oldest, then feed the rate window.
    function void push_frame(logic [HB-1:0] handle, logic [TIME_W-1:0] ms);
      int unsigned       lim;
      bit                keep;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       q;
      lim = (limit > DEPTH) ? DEPTH : limit;
      keep = 1;
      if (count >= lim) begin
        drops = bump(drops);
        if (count == 0) begin
          keep = 0;
        end else begin
          head = (head + 1) % DEPTH;
          count--;
        end
      end
      if (keep) begin
        ring[(head + count) % DEPTH] = handle;
        count++;
      end
      if (!win_open) begin
        win_start = ms;
        win_frames = '0;
        win_open = 1;
      end
      win_frames = bump(win_frames);
      elapsed = ms - win_start;
      if (elapsed >= WINDOW_MS) begin
        q = (64'(win_frames) * 64'(RATE_SCALE)) / 64'(elapsed);
        rate = (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
        win_frames = '0;
        win_start = ms;
      end
    endfunction

    // Work out the status word caused by an accepted request.
    function void note_word(req_t req, logic [HB-1:0] handle, logic [TIME_W-1:0] ms);
      frame_status_t s;
      bit            popped;
      popped = 0;
      case (req)
        REQ_PUSH: begin
          push_frame(handle, ms);
        end
        REQ_POP: begin
          popped = 1;
          if (count > 0) begin
            held = ring[head];
            held_v = 1;
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            repeats = bump(repeats);
          end
        end
        REQ_FLUSH: begin
          clear_all();
        end
        default: begin
        end
      endcase
      s.frame_valid   = popped && held_v;
      s.frame_out     = (popped && held_v) ? held : '0;
      s.queued_count  = COUNT_W'(count);
      s.has_frames    = (count > 0) || held_v;
      s.dropped_total = drops;
      s.repeats_total = repeats;
      s.rate_q8       = rate;
      status_q.push_back(s);
    endfunction

    function string show(frame_status_t s);
      return $sformatf("valid=%0d frame=%h count=%0d has=%0d drops=%0d repeats=%0d rate=%h",
                       s.frame_valid, s.frame_out, s.queued_count, s.has_frames,
                       s.dropped_total, s.repeats_total, s.rate_q8);
    endfunction

    // Compare a status word from the block against the oldest one owed.
    function void check_result(frame_status_t got);
      frame_status_t want;
      bit            bad;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR %0t: status word with none owed: %s", $time, show(got));
        return;
      end
      want = status_q.pop_front();
      bad = (got.frame_valid !== want.frame_valid) || (got.frame_out !== want.frame_out) ||
            (got.queued_count !== want.queued_count) ||
            (got.has_frames !== want.has_frames) ||
            (got.dropped_total !== want.dropped_total) ||
            (got.repeats_total !== want.repeats_total) || (got.rate_q8 !== want.rate_q8);
      if (bad) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("ERROR %0t: status word mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = '0;
  logic [HB-1:0]      frame_handle = '0;
  logic [TIME_W-1:0]  now_ms = '0;
  logic               done;
  logic               frame_valid;
  logic [HB-1:0]      frame_out;
  logic [COUNT_W-1:0] queued_count;
  logic               has_frames;
  logic [CNT_W-1:0]   dropped_total;
  logic [CNT_W-1:0]   repeats_total;
  logic [RATE_W-1:0]  rate_q8;
  logic               cfg_write = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  frame_queue_scoreboard sb;
  logic [TIME_W-1:0]     cur_ms;

  drop_oldest_frame_queue_with_rate_meter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .frame_handle  (frame_handle),
    .now_ms        (now_ms),
    .done          (done),
    .frame_valid   (frame_valid),
    .frame_out     (frame_out),
    .queued_count  (queued_count),
    .has_frames    (has_frames),
    .dropped_total (dropped_total),
    .repeats_total (repeats_total),
    .rate_q8       (rate_q8),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every status word is checked at the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result({frame_valid, frame_out, queued_count, has_frames,
                       dropped_total, repeats_total, rate_q8});
  end

  // Present one request word and hold it until the block takes it. Start is
  // left high so that a following word can go out in the next cycle.
  task automatic send_word(req_t req, logic [HB-1:0] handle, logic [TIME_W-1:0] ms);
    start <= 1'b1;
    req_type <= req;
    frame_handle <= handle;
    now_ms <= ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(req, handle, ms);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles == 0) return;
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Let every owed word come back, then write the queue limit.
  task automatic set_limit(int lim);
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((sb.pending() != 0 || busy) && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    cfg_write <= 1'b1;
    cfg_data <= COUNT_W'(lim);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.limit = COUNT_W'(lim);
  endtask

  task automatic push_at(logic [HB-1:0] handle, logic [TIME_W-1:0] ms);
    send_word(REQ_PUSH, handle, ms);
  endtask

  // Random traffic under one limit: bursts of words with random gaps, mostly
  // pushes and pops with a running clock, a few flushes and unused codes.
  task automatic run_phase(int lim, int words);
    int                push_pct;
    int                burst_left;
    int                gap;
    int                r;
    req_t              req;
    logic [TIME_W-1:0] step;
    set_limit(lim);
    push_pct = 35 + $urandom_range(0, 30);
    burst_left = $urandom_range(1, 8);
    for (int n = 0; n < words; n++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) req = REQ_PUSH;
      else if (r < 96) req = REQ_POP;
      else if (r < 98) req = REQ_FLUSH;
      else req = REQ_NONE;
      if (req == REQ_PUSH) begin
        // Mostly short steps, now and then a long silence.
        r = $urandom_range(0, 99);
        if (r < 3) step = TIME_W'($urandom_range(1000, 2000000));
        else step = TIME_W'($urandom_range(0, 350));
        cur_ms = cur_ms + step;
        push_at(HB'($urandom), cur_ms);
      end else begin
        send_word(req, HB'($urandom), TIME_W'($urandom));
      end
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        idle_gap(gap);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  // Wait for the last words to come back and give the verdict.
  task automatic finish_run();
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((sb.pending() != 0 || busy) && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.errors == 0 && sb.pending() == 0)
      $display("drop_oldest_frame_queue_with_rate_meter_core_tb passed");
    else
      $display("drop_oldest_frame_queue_with_rate_meter_core_tb failed");
    $finish;
  endtask

  initial begin
    sb = new();
  end

  // Reset, then phases under different limits. Limits are changed with frames
  // still queued, so a lowered limit meets a longer queue.
  initial begin
    cur_ms = 32'd5000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_phase(4, PHASE_WORDS);
    run_phase(1, PHASE_WORDS);
    run_phase(0, PHASE_WORDS);
    run_phase(16, PHASE_WORDS);
    run_phase(31, PHASE_WORDS);
    cur_ms = 32'hFFFF_FC00;
    run_phase(9, PHASE_WORDS);
    run_phase(3, PHASE_WORDS);
    run_phase(2, PHASE_WORDS);
    finish_run();
  end

  // Hard stop well beyond the length of a correct run.
  initial begin
    #5000000;
    $display("drop_oldest_frame_queue_with_rate_meter_core_tb failed");
    $finish;
  end

endmodule
